>>> src/mrt_pkg.sv
// Shared types and constants of the message reassembly tracker.
`default_nettype none

package mrt_pkg;

  localparam int MID_W  = 16;
  localparam int NODE_W = 12;
  localparam int LEN_W  = 20;
  localparam int IDX_W  = 16;
  localparam int TIME_W = 32;
  localparam int CODE_W = 8;
  localparam int TASK_W = 8;
  localparam int KEY_W  = MID_W + NODE_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_NUMBER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_XCVR_MODE   = CFG_IDX_W'(1);

  // Input commands
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_PARTIAL    = 3'd1,
    ST_DELIVERED  = 3'd2,
    ST_MISROUTED  = 3'd3,
    ST_NOT_STORED = 3'd4,
    ST_FULL       = 3'd5,
    ST_OVERLONG   = 3'd6
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [MID_W-1:0]  message_id;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] destination_node;
    logic [LEN_W-1:0]  message_length;
    logic [LEN_W-1:0]  packet_length;
    logic [IDX_W-1:0]  message_index;
    logic [TIME_W-1:0] receive_time;
    logic [CODE_W-1:0] node_code;
    logic [TASK_W-1:0] task_number;
  } mrt_in_t;

  typedef struct packed {
    status_t           status;
    logic              to_transceiver;
    logic [NODE_W-1:0] out_source;
    logic [MID_W-1:0]  out_message_id;
    logic [IDX_W-1:0]  out_index;
    logic [TIME_W-1:0] out_receive_time;
    logic [LEN_W-1:0]  out_length;
    logic [CODE_W-1:0] out_node_code;
    logic [TASK_W-1:0] out_task;
  } mrt_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] receive_time;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] node_code;
    logic [TASK_W-1:0] task_id;
  } mrt_desc_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_number;
    logic              transceiver_mode;
  } mrt_cfg_t;

endpackage

`default_nettype wire

>>> src/mrt_ifs.sv
// Channel interfaces of the message reassembly tracker.
`default_nettype none

interface mrt_in_if import mrt_pkg::*; ();
  logic    valid;
  logic    ready;
  mrt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface mrt_out_if import mrt_pkg::*; ();
  logic     valid;
  logic     ready;
  mrt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface mrt_cfg_if import mrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/message_reassembly_tracker_top.sv
// Top level of the message reassembly tracker.
//
// Channels: in_ch takes one word per store or packet event, out_ch returns
// exactly one status word per event in arrival order, cfg_ch writes
// node_number (index 0) and transceiver_mode (index 1); the user must
// write them only while idle, the block does not enforce it. Every
// channel moves a word at a rising edge with valid and ready high. An
// accepted word is registered, looked up in the table and its result is
// registered on out_ch. Throughput: one event per cycle while out_ch does
// not stall; the table state seen by an event already includes the update
// of the one before, through the parallel key compare over TABLE_ENTRIES
// flop-based slots. Reset (rst_n low, synchronous): all slots free,
// registers zero, both pipeline registers empty, in_ch and cfg_ch not
// ready. A stalled receiver holds the output word; one more event waits
// in the input register and in_ch drops ready until out_ch drains.
`default_nettype none

module message_reassembly_tracker_top import mrt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  mrt_in_if.sink    in_ch,
  mrt_out_if.source out_ch,
  mrt_cfg_if.sink   cfg_ch
);

  logic     item_valid;
  mrt_in_t  item;
  mrt_out_t result;
  logic     advance;
  mrt_cfg_t cfg_r;
  logic     out_valid_r, out_valid_nxt;
  mrt_out_t out_data_r;

  assign advance = item_valid && (!out_valid_r || out_ch.ready);

  mrt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mrt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (advance),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  // Configuration registers
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_NODE_NUMBER: cfg_r.node_number      <= cfg_ch.data[NODE_W-1:0];
        REG_XCVR_MODE:   cfg_r.transceiver_mode <= cfg_ch.data[0];
        default:         cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Output register: load on advance, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

>>> src/mrt_in_stage.sv
// Input register stage of the message reassembly tracker.
`default_nettype none

module mrt_in_stage import mrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mrt_in_if.sink    in_ch,
  input  wire logic advance,
  output logic      item_valid,
  output mrt_in_t   item
);

  logic    valid_r, valid_nxt;
  mrt_in_t item_r;
  logic    accept;

  // Take a word whenever the stage is empty or drains this cycle
  assign in_ch.ready = rst_n && (!valid_r || advance);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_ch.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> src/mrt_table.sv
// Reassembly table: key match, slot allocation, count update and result.
`default_nettype none

module mrt_table import mrt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic update,
  input  mrt_in_t   item,
  input  mrt_cfg_t  cfg,
  output mrt_out_t  result
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] trk_r;
  logic [TABLE_ENTRIES-1:0] dv_r;
  logic [KEY_W-1:0]         key_r  [TABLE_ENTRIES];
  logic [LEN_W-1:0]         rem_r  [TABLE_ENTRIES];
  mrt_desc_t                desc_r [TABLE_ENTRIES];

  logic [KEY_W-1:0]  key;
  logic              hit_any, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx, slot;
  logic              trk_hit, dv_hit;
  logic [LEN_W-1:0]  base;
  logic [LEN_W:0]    diff;
  logic              overlong;

  logic              key_we, trk_we, trk_val, dv_we, dv_val, rem_we, desc_we;
  mrt_out_t          res;

  assign key = {item.message_id, item.source_node};

  // Parallel key compare and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((trk_r[i] || dv_r[i]) && key_r[i] == key) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!trk_r[i] && !dv_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign trk_hit  = hit_any && trk_r[hit_idx];
  assign dv_hit   = hit_any && dv_r[hit_idx];
  assign slot     = hit_any ? hit_idx : free_idx;

  // One subtract serves both the opening and the running count
  assign base     = trk_hit ? rem_r[hit_idx] : item.message_length;
  assign diff     = {1'b0, base} - {1'b0, item.packet_length};
  assign overlong = diff[LEN_W];

  // Decide status and table writes
  always_comb begin
    key_we  = 1'b0;
    trk_we  = 1'b0;
    trk_val = 1'b0;
    dv_we   = 1'b0;
    dv_val  = 1'b0;
    rem_we  = 1'b0;
    desc_we = 1'b0;
    res     = '0;
    if (item.cmd == CMD_STORE) begin
      if (!hit_any && !free_any) begin
        res.status = ST_FULL;
      end else begin
        key_we     = !hit_any;
        trk_we     = !hit_any;
        trk_val    = 1'b0;
        dv_we      = 1'b1;
        dv_val     = 1'b1;
        desc_we    = 1'b1;
        res.status = ST_STORED;
      end
    end else if (item.destination_node != cfg.node_number) begin
      res.status = ST_MISROUTED;
    end else if (overlong) begin
      res.status = ST_OVERLONG;
    end else if (!hit_any && !free_any) begin
      res.status = ST_FULL;
    end else begin
      key_we = !hit_any;
      if (diff[LEN_W-1:0] != '0) begin
        trk_we     = 1'b1;
        trk_val    = 1'b1;
        rem_we     = 1'b1;
        dv_we      = !hit_any;
        dv_val     = 1'b0;
        res.status = ST_PARTIAL;
      end else if (!dv_hit) begin
        // Complete without descriptor: free the slot
        trk_we     = 1'b1;
        trk_val    = 1'b0;
        dv_we      = 1'b1;
        dv_val     = 1'b0;
        res.status = ST_NOT_STORED;
      end else begin
        trk_we             = 1'b1;
        trk_val            = 1'b0;
        dv_we              = 1'b1;
        dv_val             = 1'b0;
        res.status         = ST_DELIVERED;
        res.to_transceiver = cfg.transceiver_mode;
        res.out_source     = item.source_node;
        res.out_message_id = item.message_id;
        if (!cfg.transceiver_mode) begin
          res.out_index        = desc_r[slot].index;
          res.out_receive_time = desc_r[slot].receive_time;
          res.out_length       = desc_r[slot].length;
          res.out_node_code    = desc_r[slot].node_code;
          res.out_task         = desc_r[slot].task_id;
        end
      end
    end
  end

  assign result = res;

  // Valid bits clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= '0;
      dv_r  <= '0;
    end else if (update) begin
      if (trk_we) begin
        trk_r[slot] <= trk_val;
      end
      if (dv_we) begin
        dv_r[slot] <= dv_val;
      end
    end
  end

  // Keys, counts and descriptors are only read behind a valid bit
  always_ff @(posedge clk) begin
    if (update) begin
      if (key_we) begin
        key_r[slot] <= key;
      end
      if (rem_we) begin
        rem_r[slot] <= diff[LEN_W-1:0];
      end
      if (desc_we) begin
        desc_r[slot] <= '{index:        item.message_index,
                          receive_time: item.receive_time,
                          length:       item.message_length,
                          node_code:    item.node_code,
                          task_id:      item.task_number};
      end
    end
  end

endmodule

`default_nettype wire

>>> src/mrt_checker.sv
// Port-level checks of the message reassembly tracker, bound to the top.
`default_nettype none

module mrt_checker import mrt_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  mrt_in_if.sink    in_ch,
  mrt_out_if.source out_ch
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result word changed while stalled");

  // Empty pipeline after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !(in_ch.valid && in_ch.ready && !rst_n))
    else $error("result presented right after reset");

  // Only a delivery carries key and descriptor fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status != ST_DELIVERED |->
      !out_ch.data.to_transceiver && out_ch.data.out_source == '0 &&
      out_ch.data.out_message_id == '0 && out_ch.data.out_length == '0 &&
      out_ch.data.out_index == '0 && out_ch.data.out_receive_time == '0)
    else $error("fields set on a non-delivery result");

  // Transceiver notice carries no descriptor
  a_short_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.to_transceiver |->
      out_ch.data.out_index == '0 && out_ch.data.out_length == '0 &&
      out_ch.data.out_node_code == '0 && out_ch.data.out_task == '0)
    else $error("descriptor fields in transceiver notice");

endmodule

bind message_reassembly_tracker_top mrt_checker u_mrt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

>>> dv/message_reassembly_tracker_top_test.sv
// Self-checking testbench for the message reassembly tracker top level.
`timescale 1ns / 100ps

module message_reassembly_tracker_top_test;
  import mrt_pkg::*;

  localparam int SLOTS       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 140;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  // Predict every result word from a private copy of the table and registers.
  class reassembly_scoreboard;
    bit                tracking  [SLOTS];
    bit                described [SLOTS];
    logic [KEY_W-1:0]  slot_key  [SLOTS];
    logic [LEN_W-1:0]  remaining [SLOTS];
    mrt_desc_t         held_desc [SLOTS];
    logic [NODE_W-1:0] node_number;
    logic              xcvr_mode;
    mrt_out_t          awaited[$];
    int                failures;

    function void clear();
      foreach (tracking[i]) begin
        tracking[i]  = 1'b0;
        described[i] = 1'b0;
        slot_key[i]  = '0;
        remaining[i] = '0;
        held_desc[i] = '0;
      end
      node_number = '0;
      xcvr_mode   = 1'b0;
      failures    = 0;
      awaited.delete();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NODE_NUMBER: node_number = value[NODE_W-1:0];
        REG_XCVR_MODE:   xcvr_mode = value[0];
        default: ;
      endcase
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
        if ((tracking[i] || described[i]) && slot_key[i] == key) return i;
      return -1;
    endfunction

    // Lowest-numbered slot with neither valid bit set.
    function int first_free();
      for (int i = 0; i < SLOTS; i++)
        if (!tracking[i] && !described[i]) return i;
      return -1;
    endfunction

    // Apply one accepted event to the table and queue its status word.
    function void note_event(mrt_in_t w);
      mrt_out_t         res;
      logic [KEY_W-1:0] key;
      int               slot;
      bit               opening;
      bit               too_long;
      res  = '0;
      key  = {w.message_id, w.source_node};
      slot = find_key(key);
      if (w.cmd == CMD_STORE) begin
        if (slot < 0) begin
          slot = first_free();
          if (slot >= 0) begin
            slot_key[slot] = key;
            tracking[slot] = 1'b0;
          end
        end
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          described[slot]              = 1'b1;
          held_desc[slot].index        = w.message_index;
          held_desc[slot].receive_time = w.receive_time;
          held_desc[slot].length       = w.message_length;
          held_desc[slot].node_code    = w.node_code;
          held_desc[slot].task_id      = w.task_number;
          res.status = ST_STORED;
        end
      end else if (w.destination_node != node_number) begin
        res.status = ST_MISROUTED;
      end else begin
        opening = 1'b1;
        if (slot >= 0) opening = !tracking[slot];
        if (opening) too_long = w.packet_length > w.message_length;
        else too_long = w.packet_length > remaining[slot];
        if (too_long) begin
          res.status = ST_OVERLONG;
        end else begin
          if (slot < 0) begin
            slot = first_free();
            if (slot >= 0) begin
              slot_key[slot]  = key;
              described[slot] = 1'b0;
            end
          end
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            if (opening) remaining[slot] = w.message_length - w.packet_length;
            else remaining[slot] = remaining[slot] - w.packet_length;
            tracking[slot] = 1'b1;
            if (remaining[slot] != '0) begin
              res.status = ST_PARTIAL;
            end else if (!described[slot]) begin
              tracking[slot] = 1'b0;
              res.status = ST_NOT_STORED;
            end else begin
              res.status         = ST_DELIVERED;
              res.to_transceiver = xcvr_mode;
              res.out_source     = w.source_node;
              res.out_message_id = w.message_id;
              if (!xcvr_mode) begin
                res.out_index        = held_desc[slot].index;
                res.out_receive_time = held_desc[slot].receive_time;
                res.out_length       = held_desc[slot].length;
                res.out_node_code    = held_desc[slot].node_code;
                res.out_task         = held_desc[slot].task_id;
              end
              tracking[slot]  = 1'b0;
              described[slot] = 1'b0;
            end
          end
        end
      end
      awaited.push_back(res);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: %s expected %0h got %0h at %0t", field, want, seen, $realtime);
      end
    endfunction

    // Match one result word against the oldest prediction.
    function void check_result(mrt_out_t got);
      mrt_out_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: status word %0h arrived with nothing pending at %0t",
                   got.status, $realtime);
        return;
      end
      want = awaited.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("to_transceiver", 32'(want.to_transceiver), 32'(got.to_transceiver));
      compare("out_source", 32'(want.out_source), 32'(got.out_source));
      compare("out_message_id", 32'(want.out_message_id), 32'(got.out_message_id));
      compare("out_index", 32'(want.out_index), 32'(got.out_index));
      compare("out_receive_time", want.out_receive_time, got.out_receive_time);
      compare("out_length", 32'(want.out_length), 32'(got.out_length));
      compare("out_node_code", 32'(want.out_node_code), 32'(got.out_node_code));
      compare("out_task", 32'(want.out_task), 32'(got.out_task));
    endfunction
  endclass

  // One message being reassembled by the stimulus.
  typedef struct {
    logic [MID_W-1:0]  mid;
    logic [NODE_W-1:0] src;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  left;
    bit                described;
  } msg_plan_t;

  logic clk;
  logic rst_n;

  mrt_in_if  in_ch ();
  mrt_out_if out_ch ();
  mrt_cfg_if cfg_ch ();

  message_reassembly_tracker_top #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  reassembly_scoreboard sb;
  msg_plan_t            plans[$];
  logic [NODE_W-1:0]    cur_node;
  bit                   steady;
  bit                   hold_req;
  int                   hold_left;
  int                   stall_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note accepted words on every channel.
  always @(posedge clk) begin
    if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.data);
    if (in_ch.valid && in_ch.ready) sb.note_event(in_ch.data);
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // End the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Drive result ready: random stalls, one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  function automatic mrt_in_t random_word();
    mrt_in_t w;
    w.cmd              = 1'($urandom_range(0, 1));
    w.message_id       = MID_W'($urandom);
    w.source_node      = NODE_W'($urandom);
    w.destination_node = NODE_W'($urandom);
    w.message_length   = LEN_W'($urandom);
    w.packet_length    = LEN_W'($urandom);
    w.message_index    = IDX_W'($urandom);
    w.receive_time     = $urandom;
    w.node_code        = CODE_W'($urandom);
    w.task_number      = TASK_W'($urandom);
    return w;
  endfunction

  function automatic mrt_in_t shaped(logic cmd, logic [MID_W-1:0] mid, logic [NODE_W-1:0] src,
                                     logic [NODE_W-1:0] dst, logic [LEN_W-1:0] mlen,
                                     logic [LEN_W-1:0] plen);
    mrt_in_t w;
    w                  = random_word();
    w.cmd              = cmd;
    w.message_id       = mid;
    w.source_node      = src;
    w.destination_node = dst;
    w.message_length   = mlen;
    w.packet_length    = plen;
    return w;
  endfunction

  // Offer one word and hold it until accepted, then maybe drop valid before returning.
  task automatic send_item(mrt_in_t w);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Free every slot in use with a packet that completes it.
  task automatic drain_table();
    mrt_in_t sweep[$];
    mrt_in_t w;
    wait_quiet();
    for (int i = 0; i < SLOTS; i++) begin
      if (sb.tracking[i] || sb.described[i]) begin
        w = shaped(CMD_PACKET, sb.slot_key[i][KEY_W-1:NODE_W], sb.slot_key[i][NODE_W-1:0],
                   cur_node, '0, '0);
        if (sb.tracking[i]) w.packet_length = sb.remaining[i];
        sweep.push_back(w);
      end
    end
    foreach (sweep[j]) send_item(sweep[j]);
    plans.delete();
  endtask

  // Extremes, every status and the corner cases, with node number zero.
  task automatic directed_words();
    mrt_in_t w;
    // all-ones descriptor delivered by one full-length opening packet
    w = shaped(CMD_STORE, '1, '1, '0, '1, '0);
    w.message_index = '1;
    w.receive_time  = '1;
    w.node_code     = '1;
    w.task_number   = '1;
    send_item(w);
    send_item(shaped(CMD_PACKET, '1, '1, cur_node, '1, '1));
    // all-zero descriptor and zero-length message
    w = shaped(CMD_STORE, '0, '0, '1, '0, '1);
    w.message_index = '0;
    w.receive_time  = '0;
    w.node_code     = '0;
    w.task_number   = '0;
    send_item(w);
    send_item(shaped(CMD_PACKET, '0, '0, cur_node, '0, '0));
    // misrouted, completion without descriptor, overlong both ways
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, ~cur_node, 20'd10, 20'd4));
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, cur_node, '0, '0));
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, cur_node, 20'd10, 20'd11));
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, cur_node, 20'd10, 20'd4));
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, cur_node, 20'd10, 20'd7));
    // overwrite the descriptor, then finish the message
    send_item(shaped(CMD_STORE, 16'h1234, 12'h0ab, cur_node, 20'd33, '0));
    send_item(shaped(CMD_STORE, 16'h1234, 12'h0ab, cur_node, 20'd77, '0));
    send_item(shaped(CMD_PACKET, 16'h1234, 12'h0ab, cur_node, 20'd10, 20'd6));
    // fill the table, then a new key as store and as opening packet
    for (int i = 0; i < SLOTS; i++)
      send_item(shaped(CMD_STORE, MID_W'(16'h0100 + i), NODE_W'(i), cur_node, 20'd8, '0));
    send_item(shaped(CMD_STORE, 16'hbeef, 12'h123, cur_node, 20'd8, '0));
    send_item(shaped(CMD_PACKET, 16'hbeef, 12'h123, cur_node, 20'd5, 20'd1));
  endtask

  // Mostly well-formed traffic on open messages, some broken words and noise.
  task automatic random_item(int cap);
    mrt_in_t          w;
    msg_plan_t        p;
    int               pick;
    int               k;
    int               sz;
    logic [LEN_W-1:0] part;
    logic [LEN_W-1:0] bound;
    w = random_word();
    w.destination_node = cur_node;
    pick = $urandom_range(0, 99);
    if (plans.size() == 0 || (pick < 15 && plans.size() < cap)) begin
      p.mid = MID_W'($urandom);
      p.src = NODE_W'($urandom);
      sz = $urandom_range(0, 9);
      if (sz == 0) p.total = '0;
      else if (sz == 1) p.total = '1;
      else if (sz == 2) p.total = LEN_W'($urandom);
      else p.total = LEN_W'($urandom_range(1, 200));
      p.left      = p.total;
      p.described = 1'b0;
      plans.push_back(p);
      k    = plans.size() - 1;
      pick = $urandom_range(20, 84);
    end else begin
      k = $urandom_range(0, plans.size() - 1);
    end
    if (pick < 85) begin
      w.message_id  = plans[k].mid;
      w.source_node = plans[k].src;
      if (!plans[k].described && $urandom_range(0, 2) == 0) begin
        w.cmd = CMD_STORE;
        plans[k].described = 1'b1;
      end else begin
        w.cmd            = CMD_PACKET;
        w.message_length = plans[k].total;
        if ($urandom_range(0, 2) == 0) part = plans[k].left;
        else part = LEN_W'($urandom_range(0, plans[k].left));
        w.packet_length = part;
        plans[k].left   = plans[k].left - part;
        if (plans[k].left == '0) plans.delete(k);
      end
    end else if (pick < 97) begin
      w.message_id  = plans[k].mid;
      w.source_node = plans[k].src;
      w.cmd         = CMD_PACKET;
      case ($urandom_range(0, 3))
        0: w.destination_node = cur_node ^ NODE_W'($urandom_range(1, 4095));
        1: begin
          w.message_length = plans[k].total;
          bound = (plans[k].left == plans[k].total) ? plans[k].total : plans[k].left;
          if (bound > 20'hffff0) w.packet_length = '1;
          else w.packet_length = bound + LEN_W'($urandom_range(1, 8));
        end
        2: begin
          w.cmd = CMD_STORE;
          plans[k].described = 1'b1;
        end
        default: begin
          w.message_id  = MID_W'($urandom);
          w.source_node = NODE_W'($urandom);
          if ($urandom_range(0, 3) == 0) w.message_length = LEN_W'($urandom);
          else w.message_length = LEN_W'($urandom_range(0, 20));
          w.packet_length = w.message_length;
        end
      endcase
    end else begin
      w = random_word();
    end
    send_item(w);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] mode_word;
    int                    cap;
    sb = new;
    sb.clear();
    steady      = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    stall_count = 0;
    cur_node    = '0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Reprogram both registers while the block is idle.
      wait_quiet();
      case (p)
        0, 5:    cur_node = '0;
        1, 4:    cur_node = '1;
        default: cur_node = NODE_W'($urandom);
      endcase
      mode_word    = CFG_DATA_W'($urandom);
      mode_word[0] = p[0];
      write_reg(REG_NODE_NUMBER, CFG_DATA_W'(cur_node));
      write_reg(REG_XCVR_MODE, mode_word);
      steady = (p == 2);
      cap    = (p == 4 || p == 6) ? 18 : 10;
      if (p == 0) begin
        directed_words();
        drain_table();
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 3 && i == 40) hold_req = 1'b1;
        if (p == 3 && i == 90) wait_quiet();
        random_item(cap);
      end
      drain_table();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (sb.failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
